// ===== src/lpt_pkg.sv =====
`default_nettype none
package lpt_pkg;

  localparam int ADDR_W  = 24;
  localparam int PS_W    = 17;
  localparam int OFF_W   = 16;
  localparam int FIDX_W  = 4;
  localparam int PHYS_W  = 20;
  localparam int CNT_W   = 32;
  localparam int NF_W    = 5;
  localparam int REG_W   = 1;

  localparam logic [PS_W-1:0] PS_RESET = 17'd4096;
  localparam logic [PS_W-1:0] PS_MAX   = 17'd65536;
  localparam logic [NF_W-1:0] NF_RESET = 5'd16;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_PAGE_SIZE  = 1'd0;
  localparam logic [REG_W-1:0] REG_NUM_FRAMES = 1'd1;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] page;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic fault;
  } scan_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== src/lpt_div.sv =====
`default_nettype none
module lpt_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lpt_pkg::ADDR_W-1:0] dividend,
  input  wire logic [lpt_pkg::PS_W-1:0]   divisor,
  output logic                           done,
  output logic [lpt_pkg::ADDR_W-1:0]     quotient,
  output logic [lpt_pkg::OFF_W-1:0]      remainder
);

  localparam int STEPS = lpt_pkg::ADDR_W;
  localparam int SC_W  = $clog2(STEPS);

  logic                        busy;
  logic [SC_W-1:0]             cnt;
  logic [lpt_pkg::ADDR_W-1:0]  q;
  logic [lpt_pkg::OFF_W-1:0]   rem;
  logic [lpt_pkg::PS_W-1:0]    den;
  logic [lpt_pkg::PS_W-1:0]    trial;
  logic                        fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, q[lpt_pkg::ADDR_W-1]};
  assign fits  = (trial >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0) && !start;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      den <= divisor;
      rem <= '0;
      cnt <= SC_W'(STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (fits) begin
        rem <= lpt_pkg::OFF_W'(trial - den);
        q   <= {q[lpt_pkg::ADDR_W-2:0], 1'b1};
      end else begin
        rem <= trial[lpt_pkg::OFF_W-1:0];
        q   <= {q[lpt_pkg::ADDR_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = q;
  assign remainder = rem;

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, rem} < den))
    else $error("remainder not below divisor");

endmodule
`default_nettype wire

// ===== src/lpt_scan.sv =====
`default_nettype none
module lpt_scan #(
  parameter int FRAMES = 16,
  parameter int FW     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int CW     = $clog2(FRAMES + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lpt_pkg::scan_req_t        req,
  input  wire logic [CW-1:0]             count,
  input  wire logic [lpt_pkg::CNT_W-1:0] stamp,
  output lpt_pkg::scan_rsp_t             rsp,
  output logic [FW-1:0]                  frame
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;

  logic [1:0]                  state;
  logic [FRAMES-1:0]           valid;
  logic [lpt_pkg::ADDR_W-1:0]  mem_page [FRAMES];
  logic [lpt_pkg::CNT_W-1:0]   mem_use  [FRAMES];
  logic [lpt_pkg::ADDR_W-1:0]  rd_page;
  logic [lpt_pkg::CNT_W-1:0]   rd_use;
  logic [CW-1:0]               rd_idx;
  logic                        issue;
  logic                        cmp_vld;
  logic [FW-1:0]               cmp_idx;
  logic                        hit_f;
  logic                        empty_f;
  logic [FW-1:0]               hit_idx;
  logic [FW-1:0]               empty_idx;
  logic [FW-1:0]               best_idx;
  logic [lpt_pkg::CNT_W-1:0]   best_use;
  logic [FW-1:0]               pick;
  logic                        done_q;
  logic                        fault_q;

  assign issue = (state == S_SCAN) && (rd_idx < count);
  assign pick  = hit_f ? hit_idx : (empty_f ? empty_idx : best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid   <= '0;
      cmp_vld <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state == S_PICK);
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld <= issue;
          if (!issue && !cmp_vld) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          valid[pick] <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // scan index, one frame read per cycle
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx  <= rd_idx + 1'b1;
      cmp_idx <= rd_idx[FW-1:0];
    end
  end

  // compare each frame against its registered read
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      hit_f   <= 1'b0;
      empty_f <= 1'b0;
    end else if (cmp_vld) begin
      if (valid[cmp_idx] && rd_page == req.page && !hit_f) begin
        hit_f   <= 1'b1;
        hit_idx <= cmp_idx;
      end
      if (!valid[cmp_idx] && !empty_f) begin
        empty_f   <= 1'b1;
        empty_idx <= cmp_idx;
      end
      if (cmp_idx == '0 || rd_use < best_use) begin
        best_idx <= cmp_idx;
        best_use <= rd_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_page <= mem_page[rd_idx[FW-1:0]];
      rd_use  <= mem_use[rd_idx[FW-1:0]];
    end
    if (state == S_PICK) begin
      mem_use[pick] <= stamp;
      if (!hit_f) begin
        mem_page[pick] <= req.page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PICK) begin
      frame   <= pick;
      fault_q <= !hit_f;
    end
  end

  assign rsp.done  = done_q;
  assign rsp.fault = fault_q;

  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> valid[frame])
    else $error("chosen frame not marked valid");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("scan done held more than one cycle");

endmodule
`default_nettype wire

// ===== src/lru_page_translation_top.sv =====
`default_nettype none
// Flow: each beat runs through the bit-serial divider and hand-off, the
//   frame scan, the frame times page size product and the output load.
// Flow control: s_tready is high only while idle, so a new beat is taken
//   only after the last result loads; a result held by m_tready low stalls
//   the next item.
// Reset: synchronous, active high; empties all frames, clears the use and
//   fault counters, loads 4096-byte pages and 16 active frames.
module lru_page_translation_top #(
  parameter int FRAMES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        cfg_wen,
  input  wire logic [lpt_pkg::REG_W-1:0] cfg_addr,
  input  wire logic [lpt_pkg::PS_W-1:0]  cfg_wdata,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [23:0] logical address
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // [23:0] page number, [39:24] page offset,
                                      // [43:40] frame, [63:44] physical address,
                                      // [95:64] fault total
  output logic [0:0]       m_tuser    // [0] page fault
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                          state;
  logic [lpt_pkg::PS_W-1:0]            pg_bytes;
  logic [lpt_pkg::NF_W-1:0]            frame_limit;
  logic [lpt_pkg::PS_W-1:0]            eff_ps;
  logic [CW-1:0]                       eff_cnt;
  logic                                in_beat;
  logic                                div_done;
  logic [lpt_pkg::ADDR_W-1:0]          div_quot;
  logic [lpt_pkg::OFF_W-1:0]           div_rem;
  logic [lpt_pkg::ADDR_W-1:0]          page_reg;
  logic [lpt_pkg::OFF_W-1:0]           off_reg;
  logic                                scan_go;
  lpt_pkg::scan_req_t                  scan_req;
  lpt_pkg::scan_rsp_t                  scan_rsp;
  logic [FW-1:0]                       scan_frame;
  logic [FW-1:0]                       frame_reg;
  logic                                fault_reg;
  logic [FW+lpt_pkg::PS_W-1:0]         prod;
  logic [lpt_pkg::CNT_W-1:0]           use_cnt;
  logic [lpt_pkg::CNT_W-1:0]           fault_cnt;
  logic [lpt_pkg::CNT_W-1:0]           stamp;
  logic [lpt_pkg::PHYS_W-1:0]          phys;
  logic                                out_free;

  // clamp the register values to their legal ranges
  always_comb begin
    if (pg_bytes == '0) begin
      eff_ps = lpt_pkg::PS_W'(1);
    end else if (pg_bytes > lpt_pkg::PS_MAX) begin
      eff_ps = lpt_pkg::PS_MAX;
    end else begin
      eff_ps = pg_bytes;
    end
    if (frame_limit == '0) begin
      eff_cnt = CW'(1);
    end else if (32'(frame_limit) > FRAMES) begin
      eff_cnt = CW'(FRAMES);
    end else begin
      eff_cnt = CW'(frame_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pg_bytes    <= lpt_pkg::PS_RESET;
      frame_limit <= lpt_pkg::NF_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        lpt_pkg::REG_PAGE_SIZE:  pg_bytes    <= cfg_wdata;
        lpt_pkg::REG_NUM_FRAMES: frame_limit <= cfg_wdata[lpt_pkg::NF_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign stamp    = lpt_pkg::sat_inc(use_cnt);

  // page number and offset come out of the bit-serial divider
  lpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (in_beat),
    .dividend  (s_tdata[lpt_pkg::ADDR_W-1:0]),
    .divisor   (eff_ps),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign scan_req.start = scan_go;
  assign scan_req.page  = page_reg;

  // frame table: lookup, empty search and oldest search in one pass
  lpt_scan #(
    .FRAMES (FRAMES),
    .FW     (FW),
    .CW     (CW)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .req   (scan_req),
    .count (eff_cnt),
    .stamp (stamp),
    .rsp   (scan_rsp),
    .frame (scan_frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_go   <= 1'b0;
      use_cnt   <= '0;
      fault_cnt <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      scan_go <= (state == ST_DIV) && div_done;
      // raise tvalid as the result loads, drop it once the beat is taken
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_rsp.done) begin
            use_cnt <= stamp;
            if (scan_rsp.fault) begin
              fault_cnt <= lpt_pkg::sat_inc(fault_cnt);
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold the result until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_done) begin
      page_reg <= div_quot;
      off_reg  <= div_rem;
    end
    if (state == ST_SCAN && scan_rsp.done) begin
      frame_reg <= scan_frame;
      fault_reg <= scan_rsp.fault;
      prod      <= scan_frame * eff_ps;
    end
  end

  assign phys = lpt_pkg::PHYS_W'(prod) + lpt_pkg::PHYS_W'(off_reg);

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= {fault_cnt, phys, lpt_pkg::FIDX_W'(frame_reg), off_reg, page_reg};
      m_tuser <= fault_reg;
    end
  end

  a_rsp_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_rsp.done |-> (state == ST_SCAN))
    else $error("frame scan finished outside scan state");

  a_fault_le_use: assert property (@(posedge clk) disable iff (rst)
    fault_cnt <= use_cnt)
    else $error("fault count above access count");

  a_fault_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fault_cnt >= $past(fault_cnt)))
    else $error("fault count went down");

endmodule
`default_nettype wire

// ===== dv/lpt_xlat_checker.sv =====
`timescale 1ns / 100ps
module lpt_xlat_checker #(
  parameter int FRAMES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wen,
  input  wire logic [lpt_pkg::REG_W-1:0] cfg_addr,
  input  wire logic [lpt_pkg::PS_W-1:0]  cfg_wdata,
  input  wire logic                      s_tvalid,
  input  wire logic                      s_tready,
  input  wire logic [23:0]               s_tdata,
  input  wire logic                      m_tvalid,
  input  wire logic                      m_tready,
  input  wire logic [95:0]               m_tdata,
  input  wire logic [0:0]                m_tuser,
  output int                             errors,
  output int                             pending,
  output int                             checked,
  output int                             faults
);

  typedef struct packed {
    logic [lpt_pkg::ADDR_W-1:0] page;
    logic [lpt_pkg::OFF_W-1:0]  offset;
    logic [lpt_pkg::FIDX_W-1:0] frame;
    logic [lpt_pkg::PHYS_W-1:0] phys;
    logic                       fault;
    logic [lpt_pkg::CNT_W-1:0]  total;
  } xlat_t;

  logic [lpt_pkg::PS_W-1:0]   pg_bytes_q;
  logic [lpt_pkg::NF_W-1:0]   frame_limit_q;
  logic [lpt_pkg::ADDR_W-1:0] page_tag [FRAMES];
  logic                       tag_valid [FRAMES];
  logic [lpt_pkg::CNT_W-1:0]  stamp [FRAMES];
  logic [lpt_pkg::CNT_W-1:0]  use_cnt;
  logic [lpt_pkg::CNT_W-1:0]  fault_cnt;

  xlat_t xlat_expected [$];
  xlat_t want;
  xlat_t got;

  function automatic logic [lpt_pkg::CNT_W-1:0] bump_sat(
      input logic [lpt_pkg::CNT_W-1:0] v);
    return (v == {lpt_pkg::CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Translate one address and update the frame table as the block does.
  function automatic xlat_t predict_translation(input logic [lpt_pkg::ADDR_W-1:0] addr);
    logic [31:0] ps;
    logic [31:0] count;
    logic [31:0] page;
    logic [31:0] offset;
    logic [31:0] frame;
    logic        hit;
    logic        empty;
    logic [63:0] phys;
    xlat_t       r;
    if (pg_bytes_q == 0) ps = 1;
    else if (pg_bytes_q > 17'd65536) ps = 65536;
    else ps = pg_bytes_q;
    if (frame_limit_q == 0) count = 1;
    else if (frame_limit_q > FRAMES) count = FRAMES;
    else count = frame_limit_q;
    page = addr / ps;
    offset = addr % ps;
    frame = 0;
    hit = 1'b0;
    empty = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      if (i < count && tag_valid[i] && page_tag[i] == page[lpt_pkg::ADDR_W-1:0]) begin
        frame = i;
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (i < count && !tag_valid[i]) begin
          frame = i;
          empty = 1'b1;
          break;
        end
      end
      if (!empty) begin
        frame = 0;
        for (int i = 1; i < FRAMES; i++)
          if (i < count && stamp[i] < stamp[frame]) frame = i;
      end
      page_tag[frame] = page[lpt_pkg::ADDR_W-1:0];
      tag_valid[frame] = 1'b1;
      fault_cnt = bump_sat(fault_cnt);
    end
    use_cnt = bump_sat(use_cnt);
    stamp[frame] = use_cnt;
    phys = 64'(frame) * 64'(ps) + 64'(offset);
    r.page   = page[lpt_pkg::ADDR_W-1:0];
    r.offset = offset[lpt_pkg::OFF_W-1:0];
    r.frame  = frame[lpt_pkg::FIDX_W-1:0];
    r.phys   = phys[lpt_pkg::PHYS_W-1:0];
    r.fault  = !hit;
    r.total  = fault_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pg_bytes_q = lpt_pkg::PS_RESET;
      frame_limit_q = lpt_pkg::NF_RESET;
      for (int i = 0; i < FRAMES; i++) begin
        page_tag[i] = '0;
        tag_valid[i] = 1'b0;
        stamp[i] = '0;
      end
      use_cnt = '0;
      fault_cnt = '0;
      xlat_expected.delete();
    end else begin
      if (cfg_wen) begin
        if (cfg_addr == lpt_pkg::REG_PAGE_SIZE) pg_bytes_q = cfg_wdata;
        else if (cfg_addr == lpt_pkg::REG_NUM_FRAMES)
          frame_limit_q = cfg_wdata[lpt_pkg::NF_W-1:0];
      end
      if (s_tvalid && s_tready) xlat_expected.push_back(predict_translation(s_tdata));
      if (m_tvalid && m_tready) begin
        if (xlat_expected.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual tdata 0x%0h tuser %0b",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = xlat_expected.pop_front();
          got.page   = m_tdata[23:0];
          got.offset = m_tdata[39:24];
          got.frame  = m_tdata[43:40];
          got.phys   = m_tdata[63:44];
          got.total  = m_tdata[95:64];
          got.fault  = m_tuser[0];
          check_field("page_num", want.page, got.page);
          check_field("page_offset", want.offset, got.offset);
          check_field("frame_idx", want.frame, got.frame);
          check_field("phys_addr", want.phys, got.phys);
          check_field("page_fault", want.fault, got.fault);
          check_field("fault_total", want.total, got.total);
          checked++;
          if (want.fault) faults++;
        end
      end
    end
    pending = xlat_expected.size();
  end

endmodule

// ===== dv/tb_lru_page_translation_top.sv =====
`timescale 1ns / 100ps
module tb_lru_page_translation_top;

  localparam int FRAMES      = 16;
  // pad the drain wait well beyond the worst translation latency
  localparam int LAT_PAD     = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 110;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wen;
  logic [lpt_pkg::REG_W-1:0] cfg_addr;
  logic [lpt_pkg::PS_W-1:0]  cfg_wdata;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [23:0]               s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [95:0]               m_tdata;
  logic [0:0]                m_tuser;

  int errors;
  int pending;
  int checked;
  int faults;

  // knobs for the sender, the receiver and the phase sequencer
  int sender_idle_pct;
  int rx_stall_pct;
  int hold_requests;
  int hold_served;
  int hold_left;

  int beats_sent;
  int settings_used;

  // pages that the current phase revisits so that hits and evictions happen
  int unsigned hot_pages [20];
  int          n_hot;

  lru_page_translation_top #(
    .FRAMES(FRAMES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  lpt_xlat_checker #(
    .FRAMES(FRAMES)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked),
    .faults   (faults)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("[lru_page_translation_top] ERROR");
    $finish;
  end

  // Receiver: drive m_tready at each falling edge. A pending hold request
  // pulls tready low for a long stretch so the block backs up into s_tready.
  initial begin
    m_tready = 1'b0;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Offer one address beat, called and returning at a falling edge. Hold
  // tvalid across back-to-back beats; drop it only while idling.
  task automatic send_beat(input logic [23:0] addr);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata = 24'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = addr;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Wait until every result is back, then let the block drain fully.
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (LAT_PAD) @(negedge clk);
  endtask

  task automatic write_reg(input logic [lpt_pkg::REG_W-1:0] idx,
                           input logic [lpt_pkg::PS_W-1:0] val);
    cfg_wen = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wen = 1'b0;
    @(negedge clk);
  endtask

  // Reprogram both registers; only call with the block idle.
  task automatic set_geometry(input int ps_val, input int nf_val);
    s_tvalid = 1'b0;
    settle();
    write_reg(lpt_pkg::REG_PAGE_SIZE, ps_val[lpt_pkg::PS_W-1:0]);
    write_reg(lpt_pkg::REG_NUM_FRAMES, nf_val[lpt_pkg::PS_W-1:0]);
    settings_used++;
  endtask

  // Mostly revisit the hot pages, sometimes a wild address, sometimes an
  // edge of the space or of a page.
  function automatic logic [23:0] pick_address(input int unsigned ps);
    int unsigned pg;
    int unsigned a;
    int          kind;
    kind = $urandom_range(0, 99);
    pg = hot_pages[$urandom_range(0, n_hot - 1)];
    if (kind < 75) begin
      a = pg * ps + $urandom_range(0, ps - 1);
    end else if (kind < 90) begin
      a = $urandom & 32'h00FF_FFFF;
    end else begin
      case ($urandom_range(0, 3))
        0: a = 0;
        1: a = 32'h00FF_FFFF;
        2: a = pg * ps;
        default: a = pg * ps + ps - 1;
      endcase
    end
    if (a > 32'h00FF_FFFF) a = 32'h00FF_FFFF;
    return a[23:0];
  endfunction

  task automatic run_phase(input int ps_val, input int nf_val, input int idle_pct,
                           input int stall_pct, input bit squeeze);
    int unsigned ps_eff;
    int          nf_eff;
    int unsigned max_page;
    set_geometry(ps_val, nf_val);
    ps_eff = (ps_val[16:0] == 0) ? 1 : ((ps_val[16:0] > 65536) ? 65536 : ps_val[16:0]);
    nf_eff = (nf_val[4:0] == 0) ? 1 : ((nf_val[4:0] > FRAMES) ? FRAMES : nf_val[4:0]);
    max_page = 32'h00FF_FFFF / ps_eff;
    // a working set of up to three pages beyond the frame count makes evictions likely
    n_hot = nf_eff + $urandom_range(0, 3);
    for (int i = 0; i < n_hot; i++) hot_pages[i] = $urandom_range(0, max_page);
    sender_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    if (squeeze) hold_requests++;
    for (int i = 0; i < PHASE_ITEMS; i++) send_beat(pick_address(ps_eff));
    s_tvalid = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_addr = lpt_pkg::REG_PAGE_SIZE;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    hold_requests = 0;
    beats_sent = 0;
    settings_used = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: reset geometry (4096-byte pages, all frames active).
    send_beat(24'h000000);   // first fault, frame 0
    send_beat(24'hFFFFFF);   // top page, top offset
    send_beat(24'h000000);   // hit on frame 0
    send_beat(24'h000FFF);   // same page, last offset
    send_beat(24'h001000);   // next page boundary
    send_beat(24'h00A123);
    // Shrink to two frames: evict by LRU among frames 0 and 1 only.
    set_geometry(4096, 2);
    send_beat(24'h020000);
    send_beat(24'h021000);
    // Grow back: frame 3 kept its page while inactive and hits again.
    set_geometry(4096, 16);
    send_beat(24'h00A000);
    // Zero page size and zero frame count act as one.
    set_geometry(0, 0);
    send_beat(24'h000005);
    send_beat(24'h000005);
    send_beat(24'h000007);
    send_beat(24'hFFFFFF);
    // Largest legal page size.
    set_geometry(65536, 16);
    send_beat(24'hFFFFFF);
    send_beat(24'h012345);
    // Oversized page size and frame count saturate.
    set_geometry(131071, 31);
    send_beat(24'hABCDEF);
    send_beat(24'h000000);

    // Random phases across geometries and idling modes.
    run_phase(4096, 16, 0, 0, 1'b0);
    run_phase(1, 4, 74, 0, 1'b0);
    run_phase(65536, 16, 0, 74, 1'b1);
    run_phase(256, 1, 33, 33, 1'b0);
    run_phase($urandom_range(1, 65536), $urandom_range(1, 16), 0, 0, 1'b0);
    run_phase(65535, 31, 74, 0, 1'b0);
    run_phase(7, 8, 0, 74, 1'b0);
    run_phase($urandom_range(0, 131071), $urandom_range(0, 31), 33, 33, 1'b1);

    // Drain and let the pipeline go quiet before the verdict.
    settle();
    $display("Sent %0d address beats over %0d register settings and four idling modes;",
             beats_sent, settings_used);
    $display("checked %0d translations, %0d of them page faults.", checked, faults);
    if (errors == 0) begin
      $display("[lru_page_translation_top] OK");
    end else begin
      $display("[lru_page_translation_top] ERROR");
    end
    $finish;
  end

endmodule
